// ===== src/bvt_pkg.sv =====
// ----------------------------------------------------------------------------
// bvt_pkg
// Shared types and constants for the bounding volume transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bvt_pkg;

    localparam int CORDIC_STEPS = 24;
    // CORDIC unit register stages: angle fold register, one register per step, rounding register
    localparam int CLAT         = CORDIC_STEPS + 2;
    localparam int SC_W         = 18;
    localparam int CZ_W         = 34;

    localparam logic signed [CZ_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic signed [CZ_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4,
        34'sh028B0D43, 34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55,
        34'sh0028BE53, 34'sh00145F2F, 34'sh000A2F98, 34'sh000517CC,
        34'sh00028BE6, 34'sh000145F3, 34'sh0000A2F9,
        34'sh0000517C, 34'sh000028BE, 34'sh0000145F, 34'sh00000A2F,
        34'sh00000517, 34'sh0000028B, 34'sh00000145, 34'sh000000A2,
        34'sh00000051
    };

    typedef struct packed {
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
        logic [47:0]        angles_xyz;
        logic [47:0]        scales_xyz;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic [31:0]        mesh_radius;
    } bvt_in_t;

    typedef struct packed {
        logic signed [31:0] world_min_x;
        logic signed [31:0] world_min_y;
        logic signed [31:0] world_min_z;
        logic signed [31:0] world_max_x;
        logic signed [31:0] world_max_y;
        logic signed [31:0] world_max_z;
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic signed [31:0] centre_z;
        logic [31:0]        sphere_radius;
    } bvt_out_t;

    typedef struct packed {
        logic [2:0][31:0] t;
        logic [2:0][31:0] bmin;
        logic [2:0][31:0] bmax;
        logic [2:0][15:0] sc;
        logic [31:0]      rad;
    } bvt_side_t;

endpackage

`default_nettype wire

// ===== src/bvt_cordic.sv =====
// ----------------------------------------------------------------------------
// bvt_cordic
// Pipelined rotation-mode CORDIC: binary angle in, Q16 sine and cosine out.
// ----------------------------------------------------------------------------
`default_nettype none

module bvt_cordic
    import bvt_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic [15:0]            angle,
    output logic signed [SC_W-1:0] sin_q,
    output logic signed [SC_W-1:0] cos_q
);

    localparam logic [15:0] AMASK = 16'(16'hFFFF << (16 - ANGLE_BITS));

    logic [31:0] a_turn;
    logic [31:0] a_off;
    logic [31:0] a_fold;
    logic        flip;

    logic signed [CZ_W-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CZ_W-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [CZ_W-1:0] z_reg [0:CORDIC_STEPS];
    logic                   flip_reg [0:CORDIC_STEPS];

    logic signed [CZ_W-1:0] x_rnd;
    logic signed [CZ_W-1:0] y_rnd;
    logic signed [SC_W-1:0] sin_next;
    logic signed [SC_W-1:0] cos_next;
    logic signed [SC_W-1:0] sin_reg;
    logic signed [SC_W-1:0] cos_reg;

    // fold angles in [90,270) degrees by half a turn
    always_comb
    begin
        a_turn = {angle & AMASK, 16'h0000};
        a_off  = a_turn - 32'h4000_0000;
        flip   = ~a_off[31];
        a_fold = flip ? (a_turn ^ 32'h8000_0000) : a_turn;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= {{(CZ_W-32){a_fold[31]}}, a_fold};
            flip_reg[0] <= flip;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][CZ_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TURN[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TURN[i];
                end
            end
        end
    end

    always_comb
    begin
        x_rnd    = (x_reg[CORDIC_STEPS] + 34'sd8192) >>> 14;
        y_rnd    = (y_reg[CORDIC_STEPS] + 34'sd8192) >>> 14;
        cos_next = flip_reg[CORDIC_STEPS] ? -x_rnd[SC_W-1:0] : x_rnd[SC_W-1:0];
        sin_next = flip_reg[CORDIC_STEPS] ? -y_rnd[SC_W-1:0] : y_rnd[SC_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

`default_nettype wire

// ===== src/bounding_volume_transform.sv =====
// ----------------------------------------------------------------------------
// bounding_volume_transform
// World box and bounding sphere of an object under translate-rotate-scale.
// ----------------------------------------------------------------------------
//  channel   signals                                   payload
//  item      item_valid / item_ready                   item   (bvt_in_t)
//  result    result_valid / result_ready               result (bvt_out_t)
//
//  One transfer per cycle each way while result is not stalled; 33 register
//  stages, CLAT = 26 in the CORDIC pipeline plus seven matrix, product, sum,
//  clamp and output stages.
//  rst_n clears all valid bits; payload registers are not reset.
//  A stall on result freezes every stage in place; item_ready drops with it.
// ----------------------------------------------------------------------------
`default_nettype none

module bounding_volume_transform
    import bvt_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  bvt_in_t  item,
    output logic     result_valid,
    input  logic     result_ready,
    output bvt_out_t result
);

    localparam int CW = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int SH = 32 - CW;
    localparam int NS = CLAT + 6;
    localparam int KC = CLAT + 2;
    localparam int KD = CLAT + 3;
    localparam int KF = CLAT + 5;

    localparam logic [31:0]        RMASK = 32'((64'd1 << CW) - 64'd1);
    localparam logic signed [48:0] RMAX  = 49'((64'sd1 <<< CW) - 64'sd1);
    localparam logic signed [63:0] CMAX  = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] CMIN  = -CMAX - 64'sd1;

    localparam int P_C1C2 = 0;
    localparam int P_C1S2 = 1;
    localparam int P_C0S2 = 2;
    localparam int P_C0C2 = 3;
    localparam int P_S0S1 = 4;
    localparam int P_S0C1 = 5;
    localparam int P_S0S2 = 6;
    localparam int P_C0S1 = 7;
    localparam int P_S0C2 = 8;
    localparam int P_C0C1 = 9;

    function automatic logic [31:0] sext_cw(input logic [31:0] v);
        logic [31:0] tmp;
        tmp = v << SH;
        return $unsigned($signed(tmp) >>> SH);
    endfunction

    function automatic logic signed [55:0] q48(input logic signed [55:0] p);
        return p <<< 16;
    endfunction

    function automatic logic signed [19:0] rnd32(input logic signed [55:0] v);
        logic signed [55:0] tmp;
        tmp = (v + 56'sd2147483648) >>> 32;
        return tmp[19:0];
    endfunction

    logic adv;
    logic [NS-1:0] vld_reg;
    logic          result_valid_reg;
    bvt_side_t     side_next;
    bvt_side_t     side_reg [0:NS-1];

    logic signed [SC_W-1:0] sn [3];
    logic signed [SC_W-1:0] cs [3];

    logic signed [2*SC_W-1:0] pa_reg [10];
    logic signed [SC_W-1:0]   s1_a_reg;
    logic signed [SC_W-1:0]   s2_a_reg;
    logic signed [SC_W-1:0]   c2_a_reg;

    logic signed [2*SC_W-1:0] pb_reg [10];
    logic signed [SC_W-1:0]   s1_b_reg;
    logic signed [3*SC_W-1:0] s0s1c2_reg;
    logic signed [3*SC_W-1:0] s0s1s2_reg;
    logic signed [3*SC_W-1:0] c0s1c2_reg;
    logic signed [3*SC_W-1:0] c0s1s2_reg;

    logic signed [19:0] rot_next [9];
    logic signed [19:0] rot_reg  [9];

    logic signed [15:0] sc_d [3];
    logic signed [35:0] mul_d [9];
    logic signed [35:0] l_rnd [9];
    logic signed [27:0] l_reg [9];
    logic signed [15:0] big_next;
    logic signed [15:0] big_reg;

    logic signed [59:0] pmin_reg [9];
    logic signed [59:0] pmax_reg [9];
    logic signed [48:0] rp_reg;

    logic signed [63:0] lo_next [3];
    logic signed [63:0] hi_next [3];
    logic signed [63:0] lo_reg  [3];
    logic signed [63:0] hi_reg  [3];
    logic signed [48:0] rr_f;
    logic [31:0]        rad_next;
    logic [31:0]        rad_reg;

    logic signed [63:0] wlo [3];
    logic signed [63:0] whi [3];
    bvt_out_t           result_next;
    bvt_out_t           result_reg;

    assign adv        = !result_valid_reg || result_ready;
    assign item_ready = adv;

    always_comb
    begin
        side_next.t[0]    = sext_cw(item.trans_x);
        side_next.t[1]    = sext_cw(item.trans_y);
        side_next.t[2]    = sext_cw(item.trans_z);
        side_next.bmin[0] = sext_cw(item.box_min_x);
        side_next.bmin[1] = sext_cw(item.box_min_y);
        side_next.bmin[2] = sext_cw(item.box_min_z);
        side_next.bmax[0] = sext_cw(item.box_max_x);
        side_next.bmax[1] = sext_cw(item.box_max_y);
        side_next.bmax[2] = sext_cw(item.box_max_z);
        side_next.sc      = item.scales_xyz;
        side_next.rad     = item.mesh_radius & RMASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg          <= {vld_reg[NS-2:0], item_valid};
            result_valid_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k < NS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    for (genvar ax = 0; ax < 3; ax++)
    begin : g_axis
        bvt_cordic #(
            .ANGLE_BITS(ANGLE_BITS)
        ) u_cordic (
            .clk   (clk),
            .en    (adv),
            .angle (item.angles_xyz[16*ax +: 16]),
            .sin_q (sn[ax]),
            .cos_q (cs[ax])
        );
    end

    // pairwise sine/cosine products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg[P_C1C2] <= cs[1] * cs[2];
            pa_reg[P_C1S2] <= cs[1] * sn[2];
            pa_reg[P_C0S2] <= cs[0] * sn[2];
            pa_reg[P_C0C2] <= cs[0] * cs[2];
            pa_reg[P_S0S1] <= sn[0] * sn[1];
            pa_reg[P_S0C1] <= sn[0] * cs[1];
            pa_reg[P_S0S2] <= sn[0] * sn[2];
            pa_reg[P_C0S1] <= cs[0] * sn[1];
            pa_reg[P_S0C2] <= sn[0] * cs[2];
            pa_reg[P_C0C1] <= cs[0] * cs[1];
            s1_a_reg       <= sn[1];
            s2_a_reg       <= sn[2];
            c2_a_reg       <= cs[2];
        end
    end

    // triple products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pb_reg     <= pa_reg;
            s1_b_reg   <= s1_a_reg;
            s0s1c2_reg <= pa_reg[P_S0S1] * c2_a_reg;
            s0s1s2_reg <= pa_reg[P_S0S1] * s2_a_reg;
            c0s1c2_reg <= pa_reg[P_C0S1] * c2_a_reg;
            c0s1s2_reg <= pa_reg[P_C0S1] * s2_a_reg;
        end
    end

    // rotation matrix Rx*Ry*Rz, Q16
    always_comb
    begin
        rot_next[0] = rnd32(q48(pb_reg[P_C1C2]));
        rot_next[1] = rnd32(-q48(pb_reg[P_C1S2]));
        rot_next[2] = 20'(s1_b_reg);
        rot_next[3] = rnd32(q48(pb_reg[P_C0S2]) + s0s1c2_reg);
        rot_next[4] = rnd32(q48(pb_reg[P_C0C2]) - s0s1s2_reg);
        rot_next[5] = rnd32(-q48(pb_reg[P_S0C1]));
        rot_next[6] = rnd32(q48(pb_reg[P_S0S2]) - c0s1c2_reg);
        rot_next[7] = rnd32(q48(pb_reg[P_S0C2]) + c0s1s2_reg);
        rot_next[8] = rnd32(q48(pb_reg[P_C0C1]));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rot_reg <= rot_next;
        end
    end

    // scaled linear part L
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sc_d[j] = $signed(side_reg[KC].sc[j]);
        end
        for (int n = 0; n < 9; n++)
        begin
            mul_d[n] = rot_reg[n] * sc_d[n % 3];
            l_rnd[n] = (mul_d[n] + 36'sd128) >>> 8;
        end
        big_next = sc_d[0];
        if (sc_d[1] > big_next)
        begin
            big_next = sc_d[1];
        end
        if (sc_d[2] > big_next)
        begin
            big_next = sc_d[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int n = 0; n < 9; n++)
            begin
                l_reg[n] <= l_rnd[n][27:0];
            end
            big_reg <= big_next;
        end
    end

    // corner products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int n = 0; n < 9; n++)
            begin
                pmin_reg[n] <= l_reg[n] * $signed(side_reg[KD].bmin[n % 3]);
                pmax_reg[n] <= l_reg[n] * $signed(side_reg[KD].bmax[n % 3]);
            end
            rp_reg <= $signed({1'b0, side_reg[KD].rad}) * big_reg;
        end
    end

    // per-axis envelope sums, radius clamp
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lo_next[i] = '0;
            hi_next[i] = '0;
            for (int j = 0; j < 3; j++)
            begin
                if (pmin_reg[3*i+j] < pmax_reg[3*i+j])
                begin
                    lo_next[i] = lo_next[i] + pmin_reg[3*i+j];
                    hi_next[i] = hi_next[i] + pmax_reg[3*i+j];
                end
                else
                begin
                    lo_next[i] = lo_next[i] + pmax_reg[3*i+j];
                    hi_next[i] = hi_next[i] + pmin_reg[3*i+j];
                end
            end
        end
        rr_f = (rp_reg + 49'sd128) >>> 8;
        priority if (rr_f < 49'sd0)
        begin
            rad_next = '0;
        end
        else if (rr_f > RMAX)
        begin
            rad_next = RMAX[31:0];
        end
        else
        begin
            rad_next = rr_f[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            rad_reg <= rad_next;
        end
    end

    // round, translate, saturate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wlo[i] = ((lo_reg[i] + 64'sd32768) >>> 16) + $signed(side_reg[KF].t[i]);
            whi[i] = ((hi_reg[i] + 64'sd32768) >>> 16) + $signed(side_reg[KF].t[i]);
            if (wlo[i] > CMAX)
            begin
                wlo[i] = CMAX;
            end
            if (wlo[i] < CMIN)
            begin
                wlo[i] = CMIN;
            end
            if (whi[i] > CMAX)
            begin
                whi[i] = CMAX;
            end
            if (whi[i] < CMIN)
            begin
                whi[i] = CMIN;
            end
        end
        result_next.world_min_x   = wlo[0][31:0];
        result_next.world_min_y   = wlo[1][31:0];
        result_next.world_min_z   = wlo[2][31:0];
        result_next.world_max_x   = whi[0][31:0];
        result_next.world_max_y   = whi[1][31:0];
        result_next.world_max_z   = whi[2][31:0];
        result_next.centre_x      = side_reg[KF].t[0];
        result_next.centre_y      = side_reg[KF].t[1];
        result_next.centre_z      = side_reg[KF].t[2];
        result_next.sphere_radius = rad_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg) && $stable(result_valid_reg))
        else $error("pipeline moved during stall");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !item_valid |=> !vld_reg[0])
        else $error("item entered without transfer");

    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.world_min_x <= result.world_max_x) &&
                         (result.world_min_y <= result.world_max_y) &&
                         (result.world_min_z <= result.world_max_z))
        else $error("world box min above max");

    a_valid_advance: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[NS-1] |=> result_valid)
        else $error("result lost at output stage");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Bounding volume transform testbench
// Drives object transfers (directed table, then random), predicts the world
// box and sphere of each in a local fixed-point model and compares every
// result transfer in order. Sender and receiver idle at random in two of three
// phases; a long receiver hold-off makes the pipeline fill and stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import bvt_pkg::*;

    localparam int  LATENCY    = 33;
    localparam int  N_RANDOM   = 800;
    localparam int  WATCHDOG   = 20000;
    localparam int  HOLD_CYCLES = 300;

    localparam longint ATAN_STEP [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051
    };

    typedef struct {
        bvt_in_t  obj;
        bit       has_known;
        bvt_out_t known;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     item_valid;
    logic     item_ready;
    bvt_in_t  item;
    logic     result_valid;
    logic     result_ready;
    bvt_out_t result;

    bvt_out_t  expected_bounds[$];
    stim_row_t directed_rows[$];
    int        mismatches;
    int        idle_cycles;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_recv;
    bit        timed_out;

    bounding_volume_transform i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint round_shift(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void sine_cosine(input logic [15:0] ang, output longint sn,
                                        output longint cs);
        logic [31:0] a;
        bit          flip;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        a    = {ang, 16'h0000};
        flip = ((a - 32'h40000000) & 32'h80000000) == 0;
        x    = 652032874;
        y    = 0;
        if (flip)
        begin
            a = a - 32'h80000000;
        end
        z = longint'($signed(a));
        for (int i = 0; i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shift(y, i);
                y  = y + floor_shift(x, i);
                z  = z - ATAN_STEP[i];
            end
            else
            begin
                nx = x + floor_shift(y, i);
                y  = y - floor_shift(x, i);
                z  = z + ATAN_STEP[i];
            end
            x = nx;
        end
        x  = round_shift(x, 14);
        y  = round_shift(y, 14);
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic bvt_out_t transform_bounds(bvt_in_t o);
        longint   s[3];
        longint   c[3];
        longint   sc[3];
        longint   t[3];
        longint   bmin[3];
        longint   bmax[3];
        longint   r[3][3];
        longint   lo;
        longint   hi;
        longint   l;
        longint   a;
        longint   b;
        longint   big;
        longint   rad;
        longint   q;
        bvt_out_t res;
        q = longint'(1) << 32;
        for (int i = 0; i < 3; i++)
        begin
            sine_cosine(o.angles_xyz[16*i +: 16], s[i], c[i]);
            sc[i] = longint'($signed(o.scales_xyz[16*i +: 16]));
        end
        t    = '{longint'(o.trans_x), longint'(o.trans_y), longint'(o.trans_z)};
        bmin = '{longint'(o.box_min_x), longint'(o.box_min_y), longint'(o.box_min_z)};
        bmax = '{longint'(o.box_max_x), longint'(o.box_max_y), longint'(o.box_max_z)};
        r[0][0] = c[1] * c[2] * 65536;
        r[0][1] = -c[1] * s[2] * 65536;
        r[0][2] = s[1] * q;
        r[1][0] = c[0] * s[2] * 65536 + s[0] * s[1] * c[2];
        r[1][1] = c[0] * c[2] * 65536 - s[0] * s[1] * s[2];
        r[1][2] = -s[0] * c[1] * 65536;
        r[2][0] = s[0] * s[2] * 65536 - c[0] * s[1] * c[2];
        r[2][1] = s[0] * c[2] * 65536 + c[0] * s[1] * s[2];
        r[2][2] = c[0] * c[1] * 65536;
        for (int i = 0; i < 3; i++)
        begin
            lo = 0;
            hi = 0;
            for (int j = 0; j < 3; j++)
            begin
                l  = round_shift(round_shift(r[i][j], 32) * sc[j], 8);
                a  = l * bmin[j];
                b  = l * bmax[j];
                lo += a < b ? a : b;
                hi += a < b ? b : a;
            end
            lo = clamp(round_shift(lo, 16) + t[i], -64'sd2147483648, 64'sd2147483647);
            hi = clamp(round_shift(hi, 16) + t[i], -64'sd2147483648, 64'sd2147483647);
            case (i)
                0:       begin res.world_min_x = lo[31:0]; res.world_max_x = hi[31:0]; end
                1:       begin res.world_min_y = lo[31:0]; res.world_max_y = hi[31:0]; end
                default: begin res.world_min_z = lo[31:0]; res.world_max_z = hi[31:0]; end
            endcase
        end
        res.centre_x = o.trans_x;
        res.centre_y = o.trans_y;
        res.centre_z = o.trans_z;
        big = sc[0];
        if (sc[1] > big) big = sc[1];
        if (sc[2] > big) big = sc[2];
        rad = longint'(o.mesh_radius);
        rad = clamp(round_shift(rad * big, 8), 0, 64'sd4294967295);
        res.sphere_radius = rad[31:0];
        return res;
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 5))
            0:       return 32'h80000000;
            1:       return 32'h7FFFFFFF;
            2:       return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF);
        endcase
    endfunction

    function automatic logic [15:0] random_scale();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom());
            1:       return 16'h0100;
            default: return 16'($signed($urandom_range(0, 16'h0800)) - 16'sh0400);
        endcase
    endfunction

    function automatic bvt_in_t random_object();
        bvt_in_t o;
        o.trans_x     = random_coord();
        o.trans_y     = random_coord();
        o.trans_z     = random_coord();
        o.angles_xyz  = {16'($urandom()), 16'($urandom()), 16'($urandom())};
        o.scales_xyz  = {random_scale(), random_scale(), random_scale()};
        o.box_min_x   = random_coord();
        o.box_min_y   = random_coord();
        o.box_min_z   = random_coord();
        o.box_max_x   = random_coord();
        o.box_max_y   = random_coord();
        o.box_max_z   = random_coord();
        o.mesh_radius = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h00FFFFFF);
        return o;
    endfunction

    function automatic bvt_in_t make_object(logic [31:0] tr, logic [47:0] ang,
                                            logic [47:0] scl, logic [31:0] lo,
                                            logic [31:0] hi, logic [31:0] rad);
        bvt_in_t o;
        o.trans_x = tr;  o.trans_y = tr;  o.trans_z = tr;
        o.angles_xyz = ang;
        o.scales_xyz = scl;
        o.box_min_x = lo; o.box_min_y = lo; o.box_min_z = lo;
        o.box_max_x = hi; o.box_max_y = hi; o.box_max_z = hi;
        o.mesh_radius = rad;
        return o;
    endfunction

    function automatic bvt_out_t make_bounds(logic [31:0] lo, logic [31:0] hi,
                                             logic [31:0] tr, logic [31:0] rad);
        bvt_out_t r;
        r.world_min_x = lo; r.world_min_y = lo; r.world_min_z = lo;
        r.world_max_x = hi; r.world_max_y = hi; r.world_max_z = hi;
        r.centre_x = tr; r.centre_y = tr; r.centre_z = tr;
        r.sphere_radius = rad;
        return r;
    endfunction

    task automatic add_row(bvt_in_t o, bit known_valid, bvt_out_t k);
        stim_row_t row;
        row.obj       = o;
        row.has_known = known_valid;
        row.known     = k;
        directed_rows.push_back(row);
    endtask

    task automatic build_directed();
        bvt_out_t none;
        none = '0;
        // identity: zero angles, unit scales, zero box
        add_row(make_object('0, '0, 48'h0100_0100_0100, '0, '0, 32'h00010000), 1'b1,
                make_bounds('0, '0, '0, 32'h00010000));
        // zero scale collapses box onto translation, radius zero
        add_row(make_object(32'h12345678, '0, '0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF),
                1'b1, make_bounds(32'h12345678, 32'h12345678, 32'h12345678, '0));
        // negative largest scale saturates radius to zero
        add_row(make_object('0, '0, 48'hFF00_FF00_FF00, '0, 32'h00010000, 32'h00100000),
                1'b0, none);
        // saturation at both ends
        add_row(make_object(32'h7FFFFFFF, '0, 48'h7FFF_7FFF_7FFF, 32'h80000000, 32'h7FFFFFFF,
                            32'hFFFFFFFF), 1'b1,
                make_bounds(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF));
        add_row(make_object(32'h80000000, '0, 48'h8000_8000_8000, 32'h80000000, 32'h7FFFFFFF,
                            32'hFFFFFFFF), 1'b0, none);
        // quadrant boundaries of each angle
        for (int i = 0; i < 8; i++)
        begin
            add_row(make_object(32'h00010000, {3{16'(i * 16'h2000)}}, 48'h0100_0180_0200,
                                32'hFFFF0000, 32'h00020000, 32'h00010000), 1'b0, none);
        end
        add_row(make_object('0, 48'hFFFF_FFFF_FFFF, 48'h0100_0100_0100, 32'hFFFF0000,
                            32'h00010000, 32'd1), 1'b0, none);
        add_row(make_object('0, 48'h0001_7FFF_8001, 48'h0100_0100_0100, 32'hFFFF0000,
                            32'h00010000, 32'd1), 1'b0, none);
        // inverted box
        add_row(make_object('0, 48'h1000_2000_3000, 48'h0100_0100_0100, 32'h00030000,
                            32'hFFFD0000, 32'h00050000), 1'b0, none);
        // mixed signs and random angles
        add_row(make_object(32'hFFFF8000, 48'hABCD_1234_5678, 48'h0080_FF40_0300,
                            32'hFFF00000, 32'h00100000, 32'h00123456), 1'b0, none);
        add_row(make_object(32'h00008000, 48'h5555_AAAA_0F0F, 48'hFFFF_0001_8001,
                            32'h80000001, 32'h7FFFFFFE, 32'h80000000), 1'b0, none);
    endtask

    task automatic send_object(bvt_in_t o);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= o;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] exp, logic [31:0] act);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp, act);
        end
    endtask

    task automatic compare_bounds(bvt_out_t exp, bvt_out_t act);
        if (act.world_min_x !== exp.world_min_x) report_mismatch("world_min_x", exp.world_min_x, act.world_min_x);
        if (act.world_min_y !== exp.world_min_y) report_mismatch("world_min_y", exp.world_min_y, act.world_min_y);
        if (act.world_min_z !== exp.world_min_z) report_mismatch("world_min_z", exp.world_min_z, act.world_min_z);
        if (act.world_max_x !== exp.world_max_x) report_mismatch("world_max_x", exp.world_max_x, act.world_max_x);
        if (act.world_max_y !== exp.world_max_y) report_mismatch("world_max_y", exp.world_max_y, act.world_max_y);
        if (act.world_max_z !== exp.world_max_z) report_mismatch("world_max_z", exp.world_max_z, act.world_max_z);
        if (act.centre_x !== exp.centre_x) report_mismatch("centre_x", exp.centre_x, act.centre_x);
        if (act.centre_y !== exp.centre_y) report_mismatch("centre_y", exp.centre_y, act.centre_y);
        if (act.centre_z !== exp.centre_z) report_mismatch("centre_z", exp.centre_z, act.centre_z);
        if (act.sphere_radius !== exp.sphere_radius)
            report_mismatch("sphere_radius", exp.sphere_radius, act.sphere_radius);
    endtask

    // expectation is queued on the transfer edge, before the result can appear
    always @(posedge clk)
    begin
        if (rst_n && item_valid && item_ready)
        begin
            expected_bounds.push_back(transform_bounds(item));
        end
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_bounds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result transfer with no expectation", $realtime);
                end
            end
            else
            begin
                compare_bounds(expected_bounds.pop_front(), result);
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= !hold_recv && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        timed_out = 1'b0;
        wait (idle_cycles >= WATCHDOG);
        timed_out = 1'b1;
    end

    initial
    begin
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        result_ready  = 1'b0;
        mismatches    = 0;
        idle_cycles   = 0;
        hold_recv     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        build_directed();
        fork
            begin
                repeat (5) @(posedge clk);
                rst_n <= 1'b1;
                @(posedge clk);
                foreach (directed_rows[k])
                begin
                    send_object(directed_rows[k].obj);
                    if (directed_rows[k].has_known &&
                        transform_bounds(directed_rows[k].obj) !== directed_rows[k].known)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("directed row %0d: expected %h, predicted %h", k,
                                     directed_rows[k].known,
                                     transform_bounds(directed_rows[k].obj));
                        end
                    end
                end
                for (int phase = 0; phase < 3; phase++)
                begin
                    send_idle_pct = phase == 0 ? 8 : (phase == 1 ? 76 : 0);
                    recv_idle_pct = phase == 0 ? 76 : (phase == 1 ? 8 : 0);
                    for (int n = 0; n < N_RANDOM / 3; n++)
                    begin
                        if (phase == 2 && n == 20)
                        begin
                            fork
                                begin
                                    hold_recv = 1'b1;
                                    repeat (HOLD_CYCLES) @(posedge clk);
                                    hold_recv = 1'b0;
                                end
                            join_none
                        end
                        send_object(random_object());
                    end
                end
                item_valid <= 1'b0;
                while (expected_bounds.size() != 0)
                begin
                    @(posedge clk);
                end
                repeat (LATENCY + 10) @(posedge clk);
            end
            wait (timed_out);
        join_any
        if (timed_out)
        begin
            $display("Testbench completed WITH ERRORS");
        end
        else if (mismatches == 0 && expected_bounds.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
